### hdl/twlh_pkg.sv
// Shared types and constants of the travelling-wave line history block.
package twlh_pkg;

  localparam logic OP_PRELOAD = 1'b0;
  localparam logic OP_STEP    = 1'b1;

  localparam logic [2:0] REG_DELAY_STEPS       = 3'd0;
  localparam logic [2:0] REG_ALPHA             = 3'd1;
  localparam logic [2:0] REG_COEF_FAR          = 3'd2;
  localparam logic [2:0] REG_COEF_NEAR         = 3'd3;
  localparam logic [2:0] REG_BACK_IMPEDANCE    = 3'd4;
  localparam logic [2:0] REG_INV_END_IMPEDANCE = 3'd5;
  localparam logic [2:0] REG_ROT_COS           = 3'd6;
  localparam logic [2:0] REG_ROT_SIN           = 3'd7;

  localparam logic [16:0]        ALPHA_ONE   = 17'h10000;
  localparam logic [8:0]         DELAY_RESET = 9'd1;
  localparam logic signed [25:0] ROT_ONE     = 26'sh1000000;

  typedef struct packed {
    logic              operation;
    logic              first_step;
    logic signed [31:0] volt_a_re;
    logic signed [31:0] volt_a_im;
    logic signed [31:0] volt_b_re;
    logic signed [31:0] volt_b_im;
    logic signed [31:0] cur_a_re;
    logic signed [31:0] cur_a_im;
    logic signed [31:0] cur_b_re;
    logic signed [31:0] cur_b_im;
  } item_t;

  typedef struct packed {
    logic signed [31:0] src_a_re;
    logic signed [31:0] src_a_im;
    logic signed [31:0] src_b_re;
    logic signed [31:0] src_b_im;
  } result_t;

  typedef struct packed {
    logic [8:0]         delay_steps;
    logic [16:0]        alpha;
    logic signed [31:0] coef_far;
    logic signed [31:0] coef_near;
    logic signed [31:0] back_impedance;
    logic signed [31:0] inv_end_impedance;
    logic signed [25:0] rot_cos;
    logic signed [25:0] rot_sin;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_PRELOAD = 2'd0,
    CMD_FIRST   = 2'd1,
    CMD_STEP    = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    item_t     item;
  } cmd_t;

endpackage

### hdl/travelling_wave_line_history.sv
// Travelling-wave line history block: ring preload and per-step history sources.
//
// Input channel (push/full): one item per transfer. operation 0 preloads one
// entry of the delay ring; operation 1 runs one time step, which yields
// exactly one result. A two-entry queue takes items while the engine works.
// Result channel (empty/pop): the oldest result sits on result while empty is
// low; pop transfers it. A finished step waits in the engine until the output
// register frees, and the input queue keeps filling meanwhile.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data): cfg_ready is always
// high; write only while no item is in flight.
// Sequence: the engine runs one item at a time on four shared lane multipliers.
// A preload passes S_IDLE and S_WR; a first step skips the ring write and
// passes S_IDLE, S_RD0, S_RD1, S_IV0 to S_IV2, S_FS and S_OUT; any other step
// passes S_IDLE, S_WR, S_RD0, S_RD1, S_IV0 to S_IV2, S_W0, S_W1, S_S0 to S_S2,
// S_R0 to S_R2 and S_OUT. A new item is taken only in S_IDLE. The ring is read
// at two addresses, in S_RD0 and S_RD1, from one memory port.
// Reset clears the queues, ring index and held sources and loads the register
// defaults; ring contents stay undefined until preloaded or written by steps.
module travelling_wave_line_history #(
  parameter int RING_DEPTH   = 256,
  parameter int SIGNAL_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  twlh_pkg::item_t    item,
  output logic               empty,
  input  logic               pop,
  output twlh_pkg::result_t  result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  twlh_pkg::cfg_t  cfg;
  twlh_pkg::cmd_t  cmd;
  logic            cmd_valid;
  logic            cmd_take;
  logic            res_valid;

  assign cfg_ready = 1'b1;
  assign empty     = !res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delay_steps       <= twlh_pkg::DELAY_RESET;
      cfg.alpha             <= twlh_pkg::ALPHA_ONE;
      cfg.coef_far          <= '0;
      cfg.coef_near         <= '0;
      cfg.back_impedance    <= '0;
      cfg.inv_end_impedance <= '0;
      cfg.rot_cos           <= twlh_pkg::ROT_ONE;
      cfg.rot_sin           <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        twlh_pkg::REG_DELAY_STEPS:       cfg.delay_steps       <= cfg_data[8:0];
        twlh_pkg::REG_ALPHA:             cfg.alpha             <= cfg_data[16:0];
        twlh_pkg::REG_COEF_FAR:          cfg.coef_far          <= cfg_data;
        twlh_pkg::REG_COEF_NEAR:         cfg.coef_near         <= cfg_data;
        twlh_pkg::REG_BACK_IMPEDANCE:    cfg.back_impedance    <= cfg_data;
        twlh_pkg::REG_INV_END_IMPEDANCE: cfg.inv_end_impedance <= cfg_data;
        twlh_pkg::REG_ROT_COS:           cfg.rot_cos           <= cfg_data[25:0];
        twlh_pkg::REG_ROT_SIN:           cfg.rot_sin           <= cfg_data[25:0];
        default: ;
      endcase
    end
  end

  twlh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  twlh_back #(
    .RING_DEPTH   (RING_DEPTH),
    .SIGNAL_WIDTH (SIGNAL_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .res_valid (res_valid),
    .res_data  (result),
    .res_take  (pop && res_valid)
  );

endmodule

### hdl/twlh_front.sv
// Input queue: accepts items, classifies them and hands them to the engine.
module twlh_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  twlh_pkg::item_t   item,
  output logic              cmd_valid,
  output twlh_pkg::cmd_t    cmd,
  input  logic              cmd_take
);

  twlh_pkg::cmd_t q [2];
  twlh_pkg::cmd_t cls;
  logic           wp;
  logic           rp;
  logic [1:0]     cnt;
  logic           do_push;

  assign full      = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rp];
  assign do_push   = push && !full;

  always_comb begin
    cls.item = item;
    if (item.operation == twlh_pkg::OP_PRELOAD) begin
      cls.kind = twlh_pkg::CMD_PRELOAD;
    end else if (item.first_step) begin
      cls.kind = twlh_pkg::CMD_FIRST;
    end else begin
      cls.kind = twlh_pkg::CMD_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wp] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) begin
        wp <= !wp;
      end
      if (cmd_take) begin
        rp <= !rp;
      end
      cnt <= cnt + 2'(do_push) - 2'(cmd_take);
    end
  end

endmodule

### hdl/twlh_back.sv
// Step engine: delay ring memory, interpolation and history source arithmetic.
module twlh_back #(
  parameter int RING_DEPTH   = 256,
  parameter int SIGNAL_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  twlh_pkg::cfg_t     cfg,
  input  logic               cmd_valid,
  input  twlh_pkg::cmd_t     cmd,
  output logic               cmd_take,
  output logic               res_valid,
  output twlh_pkg::result_t  res_data,
  input  logic               res_take
);

  localparam int SW = SIGNAL_WIDTH;
  localparam int IW = $clog2(RING_DEPTH);
  localparam int LW = IW + 1;
  localparam int PW = 66;
  localparam int OW = 33;
  localparam int TW = 42;
  localparam logic signed [PW-1:0] SMAX  = (PW'(1) << (SW - 1)) - PW'(1);
  localparam logic signed [PW-1:0] SMIN  = ~SMAX;
  localparam logic signed [PW-1:0] RND24 = PW'(1) << 23;
  localparam logic signed [PW-1:0] RND16 = PW'(1) << 15;

  typedef enum logic [16:0] {
    S_IDLE = 17'h00001,
    S_WR   = 17'h00002,
    S_RD0  = 17'h00004,
    S_RD1  = 17'h00008,
    S_IV0  = 17'h00010,
    S_IV1  = 17'h00020,
    S_IV2  = 17'h00040,
    S_FS   = 17'h00080,
    S_W0   = 17'h00100,
    S_W1   = 17'h00200,
    S_S0   = 17'h00400,
    S_S1   = 17'h00800,
    S_S2   = 17'h01000,
    S_R0   = 17'h02000,
    S_R1   = 17'h04000,
    S_R2   = 17'h08000,
    S_OUT  = 17'h10000
  } state_t;

  function automatic logic signed [SW-1:0] sat(input logic signed [PW-1:0] x);
    if (x > SMAX) begin
      return SW'(SMAX);
    end else if (x < SMIN) begin
      return SW'(SMIN);
    end
    return SW'(x);
  endfunction

  function automatic logic signed [PW-1:0] ext(input logic signed [SW-1:0] x);
    return PW'(x);
  endfunction

  function automatic logic signed [PW-1:0] mq(input logic signed [PW-1:0] p);
    return (p + RND24) >>> 24;
  endfunction

  function automatic logic signed [SW-1:0] interp(input logic signed [PW-1:0] p,
                                                  input logic signed [SW-1:0] c2);
    return SW'((p + (ext(c2) <<< 16) + RND16) >>> 16);
  endfunction

  function automatic logic [IW-1:0] adv(input logic [IW-1:0] i, input logic [LW-1:0] n);
    if (LW'(i) + LW'(1) >= n) begin
      return '0;
    end
    return IW'(LW'(i) + LW'(1));
  endfunction

  state_t              state;
  twlh_pkg::cmd_t      itm;
  logic [IW-1:0]       idx;
  logic [IW-1:0]       idx_c;
  logic [IW-1:0]       rd_addr;
  logic [LW-1:0]       len;
  logic [16:0]         alpha_c;
  logic [8*SW-1:0]     ring_mem [RING_DEPTH];
  logic [8*SW-1:0]     rd_data;
  logic [8*SW-1:0]     c1w;
  logic [8*SW-1:0]     wd;
  logic signed [31:0]  inx  [8];
  logic signed [SW-1:0] xs  [8];
  logic signed [SW-1:0] hold [4];
  logic signed [SW-1:0] v    [4];
  logic signed [SW-1:0] c    [4];
  logic signed [SW-1:0] w    [4];
  logic signed [SW-1:0] s    [4];
  logic signed [SW-1:0] fin  [4];
  logic signed [TW-1:0] t    [4];
  logic signed [PW-1:0] prod [4];
  logic signed [OW-1:0] ma   [4];
  logic signed [OW-1:0] mb   [4];
  logic signed [OW-1:0] dv   [4];
  logic signed [OW-1:0] dc   [4];

  assign cmd_take = (state == S_IDLE) && cmd_valid;

  always_comb begin
    if (cfg.delay_steps == 9'd0) begin
      len = LW'(1);
    end else if (32'(cfg.delay_steps) > 32'(RING_DEPTH)) begin
      len = LW'(RING_DEPTH);
    end else begin
      len = LW'(cfg.delay_steps);
    end
    alpha_c = (cfg.alpha > twlh_pkg::ALPHA_ONE) ? twlh_pkg::ALPHA_ONE : cfg.alpha;
    idx_c   = (LW'(idx) >= len) ? '0 : idx;
    rd_addr = (state == S_RD0) ? idx : adv(idx, len);
  end

  // Ring write data: preload stores the inputs, a step stores the reflected values.
  always_comb begin
    inx[0] = itm.item.volt_a_re;
    inx[1] = itm.item.volt_a_im;
    inx[2] = itm.item.volt_b_re;
    inx[3] = itm.item.volt_b_im;
    inx[4] = itm.item.cur_a_re;
    inx[5] = itm.item.cur_a_im;
    inx[6] = itm.item.cur_b_re;
    inx[7] = itm.item.cur_b_im;
    for (int k = 0; k < 8; k++) begin
      xs[k] = sat(PW'(inx[k]));
    end
    for (int k = 0; k < 4; k++) begin
      if (itm.kind == twlh_pkg::CMD_PRELOAD) begin
        wd[k*SW +: SW]     = xs[k];
        wd[(k+4)*SW +: SW] = xs[k+4];
      end else begin
        wd[k*SW +: SW]     = sat(-ext(xs[k]));
        wd[(k+4)*SW +: SW] = sat(ext(hold[k]) - ext(xs[k+4]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_WR) begin
      ring_mem[idx] <= wd;
    end
    if (state == S_RD0 || state == S_RD1) begin
      rd_data <= ring_mem[rd_addr];
    end
  end

  // Operand select for the four lanes: A real, A imaginary, B real, B imaginary.
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      dv[l] = OW'(signed'(c1w[l*SW +: SW])) - OW'(signed'(rd_data[l*SW +: SW]));
      dc[l] = OW'(signed'(c1w[(l+4)*SW +: SW])) - OW'(signed'(rd_data[(l+4)*SW +: SW]));
      unique case (state)
        S_IV0: begin
          ma[l] = OW'($signed({1'b0, alpha_c}));
          mb[l] = dv[l];
        end
        S_IV1: begin
          ma[l] = OW'($signed({1'b0, alpha_c}));
          mb[l] = dc[l];
        end
        S_IV2: begin
          ma[l] = OW'(v[l]);
          mb[l] = OW'(cfg.inv_end_impedance);
        end
        S_W0: begin
          ma[l] = OW'(c[l]);
          mb[l] = OW'(cfg.back_impedance);
        end
        S_S0: begin
          ma[l] = OW'(w[l ^ 2]);
          mb[l] = OW'(cfg.coef_far);
        end
        S_S1: begin
          ma[l] = OW'(w[l]);
          mb[l] = OW'(cfg.coef_near);
        end
        S_R0: begin
          ma[l] = OW'(s[l & 2]);
          mb[l] = (l % 2 == 1) ? OW'(cfg.rot_sin) : OW'(cfg.rot_cos);
        end
        S_R1: begin
          ma[l] = OW'(s[l | 1]);
          mb[l] = (l % 2 == 1) ? OW'(cfg.rot_cos) : OW'(cfg.rot_sin);
        end
        default: begin
          ma[l] = '0;
          mb[l] = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 4; l++) begin
      prod[l] <= PW'(ma[l]) * PW'(mb[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      res_valid <= 1'b0;
      for (int l = 0; l < 4; l++) begin
        hold[l] <= '0;
      end
    end else begin
      // in S_OUT a taken result is always replaced by the new one
      if (res_take && state != S_OUT) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            itm   <= cmd;
            idx   <= idx_c;
            state <= (cmd.kind == twlh_pkg::CMD_FIRST) ? S_RD0 : S_WR;
          end
        end
        S_WR: begin
          idx   <= adv(idx, len);
          state <= (itm.kind == twlh_pkg::CMD_PRELOAD) ? S_IDLE : S_RD0;
        end
        S_RD0: state <= S_RD1;
        S_RD1: begin
          c1w   <= rd_data;
          state <= S_IV0;
        end
        S_IV0: state <= S_IV1;
        S_IV1: begin
          for (int l = 0; l < 4; l++) begin
            v[l] <= interp(prod[l], signed'(rd_data[l*SW +: SW]));
          end
          state <= S_IV2;
        end
        S_IV2: begin
          for (int l = 0; l < 4; l++) begin
            c[l] <= interp(prod[l], signed'(rd_data[(l+4)*SW +: SW]));
          end
          state <= (itm.kind == twlh_pkg::CMD_FIRST) ? S_FS : S_W0;
        end
        S_FS: begin
          for (int l = 0; l < 4; l++) begin
            fin[l] <= sat(ext(c[l]) - mq(prod[l]));
          end
          state <= S_OUT;
        end
        S_W0: state <= S_W1;
        S_W1: begin
          for (int l = 0; l < 4; l++) begin
            w[l] <= sat(ext(v[l]) + mq(prod[l]));
          end
          state <= S_S0;
        end
        S_S0: state <= S_S1;
        S_S1: begin
          for (int l = 0; l < 4; l++) begin
            t[l] <= TW'(mq(prod[l]));
          end
          state <= S_S2;
        end
        S_S2: begin
          for (int l = 0; l < 4; l++) begin
            s[l] <= sat(PW'(t[l]) + mq(prod[l]));
          end
          state <= S_R0;
        end
        S_R0: state <= S_R1;
        S_R1: begin
          for (int l = 0; l < 4; l++) begin
            t[l] <= TW'(mq(prod[l]));
          end
          state <= S_R2;
        end
        S_R2: begin
          for (int l = 0; l < 4; l++) begin
            if (l % 2 == 1) begin
              fin[l] <= sat(PW'(t[l]) + mq(prod[l]));
            end else begin
              fin[l] <= sat(PW'(t[l]) - mq(prod[l]));
            end
          end
          state <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register is free
          if (!res_valid || res_take) begin
            res_valid         <= 1'b1;
            res_data.src_a_re <= 32'(fin[0]);
            res_data.src_a_im <= 32'(fin[1]);
            res_data.src_b_re <= 32'(fin[2]);
            res_data.src_b_im <= 32'(fin[3]);
            for (int l = 0; l < 4; l++) begin
              hold[l] <= fin[l];
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_idx_in_ring: assert property (@(posedge clk) disable iff (rst)
    state == S_WR |=> LW'(idx) < len)
    else $error("ring index left the ring after a write");

  a_first_no_write: assert property (@(posedge clk) disable iff (rst)
    cmd_take && cmd.kind == twlh_pkg::CMD_FIRST |=> state == S_RD0)
    else $error("first step did not skip the ring write");

  a_first_path: assert property (@(posedge clk) disable iff (rst)
    state == S_IV2 && itm.kind == twlh_pkg::CMD_FIRST |=> state == S_FS)
    else $error("first step took the wave path");

  a_out_done: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT && !res_valid |=> res_valid && state == S_IDLE)
    else $error("free output register not loaded");

endmodule
